// ===== sv/gys_pkg.sv =====
// Shared constants, tables and control types of the gamma-aware YCbCr subsampler.
`timescale 1ns / 1ps
`default_nettype none
package gys_pkg;

  localparam int MaxGroup = 16;
  localparam int LinFrac  = 4;
  localparam int LinW     = 18 + LinFrac;
  localparam int CntW     = $clog2(MaxGroup + 1);
  localparam int SumW     = LinW + $clog2(MaxGroup);
  localparam int DivW     = (SumW > LinW + 8) ? SumW : LinW + 8;
  localparam int AccW     = 36;
  localparam int CfgW     = 5;
  localparam int GamW     = 16;
  localparam int CoefW    = 18;

  localparam logic signed [AccW-1:0] ChromaBase = AccW'(128) <<< 24;

  localparam logic signed [CoefW-1:0] CyR   = CoefW'(19595);
  localparam logic signed [CoefW-1:0] CyG   = CoefW'(38470);
  localparam logic signed [CoefW-1:0] CyB   = CoefW'(7471);
  localparam logic signed [CoefW-1:0] CbR   = -CoefW'(11058);
  localparam logic signed [CoefW-1:0] CbG   = -CoefW'(21710);
  localparam logic signed [CoefW-1:0] ChHalf = CoefW'(32768);
  localparam logic signed [CoefW-1:0] CrG   = -CoefW'(27439);
  localparam logic signed [CoefW-1:0] CrB   = -CoefW'(5329);

  localparam logic GrpLuma   = 1'b0;
  localparam logic GrpChroma = 1'b1;

  typedef logic [LinW-1:0] lin_tab_t [256];

  // round(v^2.2 * 2^LinFrac): largest n with (2n-1)^5 < 32 * v^11 * 2^(5*LinFrac)
  function automatic lin_tab_t build_lin_tab();
    lin_tab_t     t;
    logic [127:0] target;
    logic [127:0] probe;
    logic [127:0] lo;
    logic [127:0] hi;
    logic [127:0] mid;
    logic [127:0] odd;
    for (int v = 0; v < 256; v++) begin
      target = 128'd1;
      for (int k = 0; k < 11; k++) target = target * 128'(v);
      target = target << (5 * LinFrac + 5);
      lo = '0;
      hi = 128'd1 << (19 + LinFrac);
      for (int i = 0; i < 20 + LinFrac; i++) begin
        if (hi - lo > 128'd1) begin
          mid = lo + ((hi - lo) >> 1);
          odd = (mid << 1) - 128'd1;
          probe = 128'd1;
          for (int k = 0; k < 5; k++) probe = probe * odd;
          if (probe < target) lo = mid;
          else hi = mid;
        end
      end
      t[v] = lo[LinW-1:0];
    end
    return t;
  endfunction

  localparam lin_tab_t LinTab = build_lin_tab();

  function automatic logic [CntW:0] eff_size(input logic [CfgW-1:0] g);
    if (g == '0) return (CntW+1)'(1);
    if (32'(g) > MaxGroup) return (CntW+1)'(MaxGroup);
    return (CntW+1)'(g);
  endfunction

  function automatic logic signed [CoefW-1:0] mat_coef(input logic grp, input logic [2:0] k);
    logic signed [CoefW-1:0] c;
    c = '0;
    unique case ({grp, k})
      {GrpLuma, 3'd0}:   c = CyR;
      {GrpLuma, 3'd1}:   c = CyG;
      {GrpLuma, 3'd2}:   c = CyB;
      {GrpChroma, 3'd0}: c = CbR;
      {GrpChroma, 3'd1}: c = CbG;
      {GrpChroma, 3'd2}: c = ChHalf;
      {GrpChroma, 3'd3}: c = ChHalf;
      {GrpChroma, 3'd4}: c = CrG;
      {GrpChroma, 3'd5}: c = CrB;
      default:           c = '0;
    endcase
    return c;
  endfunction

  typedef struct packed {
    logic       acc;
    logic       grp;
    logic [1:0] ch;
    logic       avg_start;
    logic       avg_cap;
    logic       search;
    logic [2:0] step;
    logic       int_start;
    logic       store;
    logic       mac_clr;
    logic       mac;
    logic       emit;
    logic       run_last;
    logic       seg_last;
  } gys_cmd_t;

  typedef struct packed {
    logic luma_close;
    logic chroma_close;
    logic div_done;
    logic out_free;
  } gys_sts_t;

endpackage
`default_nettype wire

// ===== sv/gys_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gys_div (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [gys_pkg::DivW-1:0] dividend_i,
  input  wire logic [gys_pkg::LinW-1:0] divisor_i,
  output logic      [gys_pkg::DivW-1:0] quot_o,
  output logic                          done_o
);
  import gys_pkg::*;

  localparam int CW = $clog2(DivW);

  logic [DivW-1:0] num_q, num_d;
  logic [LinW-1:0] rem_q, rem_d;
  logic [LinW-1:0] dsr_q, dsr_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [LinW:0]   trial;
  logic            fits;

  assign trial = {rem_q, num_q[DivW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? LinW'(trial - {1'b0, dsr_q}) : trial[LinW-1:0];
      num_d = {num_q[DivW-2:0], fits};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quot_o = num_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

// ===== sv/gys_dp.sv =====
// Datapath: linear accumulators, divider, gamma search, matrix and output register.
`timescale 1ns / 1ps
`default_nettype none
module gys_dp (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire gys_pkg::gys_cmd_t        cmd_i,
  output gys_pkg::gys_sts_t             sts_o,
  input  wire logic [23:0]              pix_i,
  input  wire logic                     seg_end_i,
  input  wire logic [gys_pkg::CfgW-1:0] luma_group_i,
  input  wire logic [gys_pkg::CfgW-1:0] chroma_group_i,
  output logic                          m_valid_o,
  input  wire logic                     m_ready_i,
  output logic [31:0]                   m_data_o,
  output logic                          m_last_o,
  output logic [1:0]                    m_user_o
);
  import gys_pkg::*;

  logic [SumW-1:0] lsum_q [3];
  logic [SumW-1:0] csum_q [3];
  logic [CntW-1:0] lcnt_q, ccnt_q;
  logic [LinW-1:0] lin [3];
  logic [CntW:0]   lnext, cnext;

  logic [LinW-1:0] a_q;
  logic [7:0]      idx_q;
  logic [GamW-1:0] gam_q [3];
  logic signed [AccW-1:0] acc_a_q, acc_b_q;

  logic [DivW-1:0] div_num;
  logic [LinW-1:0] div_dsr;
  logic [DivW-1:0] quot;
  logic            div_done;
  logic            div_start;

  logic [SumW-1:0] sel_sum;
  logic [CntW-1:0] sel_cnt;
  logic [LinW-1:0] tab_lo, tab_hi, span, diff;
  logic [8:0]      cand;
  logic [7:0]      stepv;
  logic [1:0]      gsel;
  logic signed [CoefW-1:0]   coef;
  logic signed [AccW-1:0]    prod;
  logic [AccW-1:0]           y_sh;

  logic            out_valid_q, out_kind_q, out_rl_q, out_sl_q;
  logic [7:0]      out_luma_q;
  logic [11:0]     out_cb_q, out_cr_q;
  logic            out_free;

  function automatic logic [11:0] round84(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] t;
    logic [AccW-1:0]        q;
    t = v + (AccW'(1) <<< 19);
    q = AccW'(t) >> 20;
    if (t < 0) return 12'd0;
    if (q > AccW'(4095)) return 12'd4095;
    return q[11:0];
  endfunction

  assign lin[0] = LinTab[pix_i[7:0]];
  assign lin[1] = LinTab[pix_i[15:8]];
  assign lin[2] = LinTab[pix_i[23:16]];
  assign lnext  = {1'b0, lcnt_q} + (CntW+1)'(1);
  assign cnext  = {1'b0, ccnt_q} + (CntW+1)'(1);

  assign sel_sum = cmd_i.grp ? csum_q[cmd_i.ch] : lsum_q[cmd_i.ch];
  assign sel_cnt = cmd_i.grp ? ccnt_q : lcnt_q;

  assign tab_lo = LinTab[idx_q];
  assign tab_hi = LinTab[idx_q + 8'd1];
  assign span   = tab_hi - tab_lo;
  assign diff   = a_q - tab_lo;
  assign stepv  = 8'd128 >> cmd_i.step;
  assign cand   = {1'b0, idx_q} + {1'b0, stepv};

  assign div_start = cmd_i.avg_start | cmd_i.int_start;
  assign div_num   = cmd_i.avg_start ? DivW'(sel_sum) : DivW'({diff, 8'd0});
  assign div_dsr   = cmd_i.avg_start ? LinW'(sel_cnt) : span;

  gys_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_dsr),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  assign gsel = (cmd_i.step >= 3'd3) ? 2'(cmd_i.step - 3'd3) : cmd_i.step[1:0];
  assign coef = mat_coef(cmd_i.grp, cmd_i.step);
  assign prod = AccW'(signed'({1'b0, gam_q[gsel]})) * AccW'(coef);
  assign y_sh = AccW'(acc_a_q) >> 24;

  assign out_free = !out_valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 3; c++) begin
        lsum_q[c] <= '0;
        csum_q[c] <= '0;
      end
      lcnt_q      <= '0;
      ccnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc) begin
        for (int c = 0; c < 3; c++) begin
          lsum_q[c] <= lsum_q[c] + SumW'(lin[c]);
          csum_q[c] <= csum_q[c] + SumW'(lin[c]);
        end
        lcnt_q <= lnext[CntW-1:0];
        ccnt_q <= cnext[CntW-1:0];
      end else if (cmd_i.emit) begin
        if (cmd_i.grp) begin
          for (int c = 0; c < 3; c++) csum_q[c] <= '0;
          ccnt_q <= '0;
        end else begin
          for (int c = 0; c < 3; c++) lsum_q[c] <= '0;
          lcnt_q <= '0;
        end
      end
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (m_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.avg_cap) begin
      a_q   <= quot[LinW-1:0];
      idx_q <= '0;
    end else if (cmd_i.search) begin
      if (cand <= 9'd255 && LinTab[cand[7:0]] <= a_q) idx_q <= cand[7:0];
    end
    if (cmd_i.store) begin
      if (idx_q == 8'd255) gam_q[cmd_i.ch] <= 16'hFF00;
      else if (span == '0) gam_q[cmd_i.ch] <= {idx_q, 8'd0};
      else gam_q[cmd_i.ch] <= {idx_q, quot[7:0]};
    end
    if (cmd_i.mac_clr) begin
      acc_a_q <= cmd_i.grp ? ChromaBase : '0;
      acc_b_q <= ChromaBase;
    end else if (cmd_i.mac) begin
      if (cmd_i.grp && cmd_i.step >= 3'd3) acc_b_q <= acc_b_q + prod;
      else acc_a_q <= acc_a_q + prod;
    end
    if (cmd_i.emit) begin
      out_kind_q <= cmd_i.grp;
      out_rl_q   <= cmd_i.run_last;
      out_sl_q   <= cmd_i.seg_last;
      if (cmd_i.grp) begin
        out_luma_q <= '0;
        out_cb_q   <= round84(acc_a_q);
        out_cr_q   <= round84(acc_b_q);
      end else begin
        out_luma_q <= (y_sh > AccW'(255)) ? 8'd255 : y_sh[7:0];
        out_cb_q   <= '0;
        out_cr_q   <= '0;
      end
    end
  end

  assign sts_o.luma_close   = seg_end_i || lnext >= eff_size(luma_group_i);
  assign sts_o.chroma_close = seg_end_i || cnext >= eff_size(chroma_group_i);
  assign sts_o.div_done     = div_done;
  assign sts_o.out_free     = out_free;

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {out_cr_q, out_cb_q, out_luma_q};
  assign m_last_o  = out_rl_q;
  assign m_user_o  = {out_sl_q, out_kind_q};

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || m_ready_i)) else $error("result overwrites pending item");
  a_acc_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc |-> !cmd_i.emit) else $error("accumulate during emit");
  a_div_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.avg_start |-> sel_cnt != '0) else $error("average of empty group");

endmodule
`default_nettype wire

// ===== sv/gys_ctrl.sv =====
// Controller: sequences accumulate, average, search, interpolate, matrix and emit.
`timescale 1ns / 1ps
`default_nettype none
module gys_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  input  wire logic              s_last_i,
  output logic                   s_ready_o,
  input  wire gys_pkg::gys_sts_t sts_i,
  output gys_pkg::gys_cmd_t      cmd_o
);
  import gys_pkg::*;

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StAvgGo   = 4'd1;
  localparam logic [3:0] StAvgWait = 4'd2;
  localparam logic [3:0] StSrch    = 4'd3;
  localparam logic [3:0] StIntGo   = 4'd4;
  localparam logic [3:0] StIntWait = 4'd5;
  localparam logic [3:0] StStore   = 4'd6;
  localparam logic [3:0] StMac     = 4'd7;
  localparam logic [3:0] StEmit    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       grp_q, grp_d;
  logic [1:0] ch_q, ch_d;
  logic [2:0] step_q, step_d;
  logic       cp_q, cp_d;
  logic       last_q, last_d;

  always_comb begin
    state_d   = state_q;
    grp_d     = grp_q;
    ch_d      = ch_q;
    step_d    = step_q;
    cp_d      = cp_q;
    last_d    = last_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    cmd_o.grp  = grp_q;
    cmd_o.ch   = ch_q;
    cmd_o.step = step_q;
    cmd_o.run_last = grp_q | !cp_q;
    cmd_o.seg_last = last_q & (grp_q | !cp_q);
    unique case (state_q)
      StIdle: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.acc = 1'b1;
          cp_d   = sts_i.chroma_close;
          last_d = s_last_i;
          ch_d   = '0;
          if (sts_i.luma_close) begin
            grp_d   = GrpLuma;
            state_d = StAvgGo;
          end else if (sts_i.chroma_close) begin
            grp_d   = GrpChroma;
            state_d = StAvgGo;
          end
        end
      end
      StAvgGo: begin
        cmd_o.avg_start = 1'b1;
        state_d = StAvgWait;
      end
      StAvgWait: begin
        if (sts_i.div_done) begin
          cmd_o.avg_cap = 1'b1;
          step_d  = '0;
          state_d = StSrch;
        end
      end
      StSrch: begin
        cmd_o.search = 1'b1;
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) state_d = StIntGo;
      end
      StIntGo: begin
        cmd_o.int_start = 1'b1;
        state_d = StIntWait;
      end
      StIntWait: begin
        if (sts_i.div_done) state_d = StStore;
      end
      StStore: begin
        cmd_o.store = 1'b1;
        if (ch_q == 2'd2) begin
          cmd_o.mac_clr = 1'b1;
          step_d  = '0;
          state_d = StMac;
        end else begin
          ch_d    = ch_q + 2'd1;
          state_d = StAvgGo;
        end
      end
      StMac: begin
        cmd_o.mac = 1'b1;
        step_d = step_q + 3'd1;
        if (step_q == (grp_q ? 3'd5 : 3'd2)) state_d = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!grp_q && cp_q) begin
            grp_d   = GrpChroma;
            ch_d    = '0;
            state_d = StAvgGo;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      grp_q   <= GrpLuma;
      ch_q    <= '0;
      step_q  <= '0;
      cp_q    <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      ch_q    <= ch_d;
      step_q  <= step_d;
      cp_q    <= cp_d;
      last_q  <= last_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/gamma_aware_ycbcr_subsampler.sv =====
// Top level of the gamma-aware RGB to YCbCr subsampler with its register port.
// Input stream: one RGB pixel per item, tlast marks the last pixel of a segment.
// Output stream: luma or chroma-pair items as groups close, luma before chroma
// when one pixel closes both; tlast marks the last item caused by a pixel.
// Registers: luma_group at 0x0, chroma_group at 0x4 (reset 1 and 4).
// A pixel that closes no group is only accumulated. Each closed group runs, per
// channel, an average on the shared serial divider, the 8-step table search, an
// interpolation on the same divider and one store; then follow 3 (luma) or 6
// (chroma) matrix steps and one emit.
// No new pixel is taken while the closed groups of a pixel are processed.
// The next pixel is taken once the last result sits in the output register.
// Reset clears sums, counts, the sequencer and the output valid flag; no
// clearing pass is needed. When the receiver stalls, the finished item holds
// in the output register and the sequencer waits before emitting another.
`timescale 1ns / 1ps
`default_nettype none
module gamma_aware_ycbcr_subsampler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // luma[7:0], blue_diff[19:8], red_diff[31:20]
  output logic             m_axis_tlast,
  output logic [1:0]       m_axis_tuser,   // kind[0], segment_last[1]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import gys_pkg::*;

  localparam logic RegLumaGroup   = 1'b0;
  localparam logic RegChromaGroup = 1'b1;

  logic [CfgW-1:0] luma_group_q, chroma_group_q;
  gys_cmd_t        cmd;
  gys_sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_group_q   <= CfgW'(1);
      chroma_group_q <= CfgW'(4);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegLumaGroup:   luma_group_q   <= pwdata[CfgW-1:0];
        RegChromaGroup: chroma_group_q <= pwdata[CfgW-1:0];
        default:        ;
      endcase
    end
  end

  assign prdata = (paddr[2] == RegChromaGroup) ? 32'(chroma_group_q) : 32'(luma_group_q);

  gys_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  gys_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pix_i          (s_axis_tdata),
    .seg_end_i      (s_axis_tlast),
    .luma_group_i   (luma_group_q),
    .chroma_group_i (chroma_group_q),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_data_o       (m_axis_tdata),
    .m_last_o       (m_axis_tlast),
    .m_user_o       (m_axis_tuser)
  );

endmodule
`default_nettype wire

// ===== tb/gamma_aware_ycbcr_subsampler_tb.sv =====
// Randomized self-checking testbench of the gamma-aware YCbCr subsampler.
`timescale 1ns / 1ps
module gamma_aware_ycbcr_subsampler_tb;
  import gys_pkg::*;

  localparam int RegLuma   = 0;
  localparam int RegChroma = 1;
  localparam int DrainWait = 400;
  localparam int StallLimit = 20000;
  localparam int RandPerPhase = 70;

  typedef struct packed {
    logic        kind;
    logic [7:0]  luma;
    logic [11:0] blue_diff;
    logic [11:0] red_diff;
    logic        run_last;
    logic        seg_last;
  } ycc_item_t;

  class ycc_scoreboard;
    logic [31:0]   lin_lut [256];
    logic [CfgW-1:0] luma_size;
    logic [CfgW-1:0] chroma_size;
    logic [31:0]   luma_acc [3];
    logic [31:0]   chroma_acc [3];
    int            luma_cnt;
    int            chroma_cnt;
    ycc_item_t     pending_q [$];
    int            errors;

    function new();
      logic [127:0] goal;
      logic [127:0] pw;
      logic [127:0] lo;
      logic [127:0] hi;
      logic [127:0] mid;
      for (int v = 0; v < 256; v++) begin
        goal = 128'd1;
        for (int k = 0; k < 11; k++) goal = goal * 128'(v);
        goal = goal << 25;
        lo = '0;
        hi = 128'd1 << 23;
        while (hi - lo > 1) begin
          mid = (lo + hi) >> 1;
          pw = 128'd1;
          for (int k = 0; k < 5; k++) pw = pw * (2 * mid - 1);
          if (pw < goal) lo = mid;
          else hi = mid;
        end
        lin_lut[v] = lo[31:0];
      end
      luma_size = 1;
      chroma_size = 4;
      errors = 0;
      clear_luma();
      clear_chroma();
    endfunction

    function void clear_luma();
      foreach (luma_acc[c]) luma_acc[c] = '0;
      luma_cnt = 0;
    endfunction

    function void clear_chroma();
      foreach (chroma_acc[c]) chroma_acc[c] = '0;
      chroma_cnt = 0;
    endfunction

    function int group_size(logic [CfgW-1:0] g);
      if (g == 0) return 1;
      if (g > MaxGroup) return MaxGroup;
      return g;
    endfunction

    function longint to_gamma(logic [31:0] sum, int cnt);
      longint avg;
      longint span;
      int     idx;
      avg = sum / cnt;
      idx = 0;
      for (int step = 128; step >= 1; step = step / 2)
        if (idx + step <= 255 && lin_lut[idx + step] <= avg) idx += step;
      if (idx >= 255) return 255 << 8;
      span = lin_lut[idx + 1] - lin_lut[idx];
      if (span == 0) return idx << 8;
      return (idx << 8) + (((avg - lin_lut[idx]) << 8) / span);
    endfunction

    function logic [11:0] round_fix(longint v);
      longint t;
      t = v + (64'sd1 << 19);
      if (t < 0) return 0;
      t = t >>> 20;
      return (t > 4095) ? 12'd4095 : t[11:0];
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      if (idx == RegLuma) luma_size = val[CfgW-1:0];
      else if (idx == RegChroma) chroma_size = val[CfgW-1:0];
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic seg_end);
      ycc_item_t res [$];
      ycc_item_t it;
      longint    cr, cg, cb, y, cbv, crv;
      luma_acc[0] += lin_lut[r];
      luma_acc[1] += lin_lut[g];
      luma_acc[2] += lin_lut[b];
      chroma_acc[0] += lin_lut[r];
      chroma_acc[1] += lin_lut[g];
      chroma_acc[2] += lin_lut[b];
      luma_cnt++;
      chroma_cnt++;
      if (seg_end || luma_cnt >= group_size(luma_size)) begin
        cr = to_gamma(luma_acc[0], luma_cnt);
        cg = to_gamma(luma_acc[1], luma_cnt);
        cb = to_gamma(luma_acc[2], luma_cnt);
        y = (19595 * cr + 38470 * cg + 7471 * cb) >>> 24;
        it = '0;
        it.kind = GrpLuma;
        it.luma = (y > 255) ? 8'd255 : y[7:0];
        res = {res, it};
        clear_luma();
      end
      if (seg_end || chroma_cnt >= group_size(chroma_size)) begin
        cr = to_gamma(chroma_acc[0], chroma_cnt);
        cg = to_gamma(chroma_acc[1], chroma_cnt);
        cb = to_gamma(chroma_acc[2], chroma_cnt);
        cbv = (64'sd128 << 24) - 11058 * cr - 21710 * cg + 32768 * cb;
        crv = (64'sd128 << 24) + 32768 * cr - 27439 * cg - 5329 * cb;
        it = '0;
        it.kind = GrpChroma;
        it.blue_diff = round_fix(cbv);
        it.red_diff = round_fix(crv);
        res = {res, it};
        clear_chroma();
      end
      if (res.size() > 0) begin
        res[res.size() - 1].run_last = 1'b1;
        res[res.size() - 1].seg_last = seg_end;
      end
      foreach (res[i]) pending_q = {pending_q, res[i]};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check(ycc_item_t got);
      ycc_item_t want;
      if (pending_q.size() == 0) begin
        report("unexpected item", 32'(got), 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind != want.kind) report("kind", 32'(got.kind), 32'(want.kind));
      if (got.luma != want.luma) report("luma", 32'(got.luma), 32'(want.luma));
      if (got.blue_diff != want.blue_diff)
        report("blue_diff", 32'(got.blue_diff), 32'(want.blue_diff));
      if (got.red_diff != want.red_diff)
        report("red_diff", 32'(got.red_diff), 32'(want.red_diff));
      if (got.run_last != want.run_last)
        report("run_last", 32'(got.run_last), 32'(want.run_last));
      if (got.seg_last != want.seg_last)
        report("segment_last", 32'(got.seg_last), 32'(want.seg_last));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ycc_scoreboard sb;
  int burst_left;
  int stall_mode;
  int mode_left;
  int quiet_cycles;

  gamma_aware_ycbcr_subsampler dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(10, 80);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      default: begin
        m_axis_tready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    ycc_item_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser[0];
      got.luma = m_axis_tdata[7:0];
      got.blue_diff = m_axis_tdata[19:8];
      got.red_diff = m_axis_tdata[31:20];
      got.run_last = m_axis_tlast;
      got.seg_last = m_axis_tuser[1];
      sb.check(got);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task write_reg(int idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic seg_end);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    s_axis_tlast <= seg_end;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    sb.note_pixel(r, g, b, seg_end);
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function logic [7:0] rand_channel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task random_phase(int n);
    for (int i = 0; i < n; i++)
      send_pixel(rand_channel(), rand_channel(), rand_channel(), $urandom_range(0, 5) == 0);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
    send_pixel(8'd1, 8'd254, 8'd128, 1'b0);
    send_pixel(8'd0, 8'd255, 8'd255, 1'b1);
    drain();
    write_reg(RegLuma, 32'd16);
    write_reg(RegChroma, 32'd16);
    for (int i = 0; i < 17; i++) send_pixel(8'(i * 15), 8'(255 - i * 15), 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
    random_phase(RandPerPhase);
    drain();
    write_reg(RegLuma, 32'd0);
    write_reg(RegChroma, 32'd0);
    random_phase(RandPerPhase / 2);
    drain();
    write_reg(RegLuma, 32'hFFFF_FFFF);
    write_reg(RegChroma, 32'd17);
    random_phase(RandPerPhase);
    drain();
    write_reg(RegLuma, 32'd3);
    write_reg(RegChroma, 32'd1);
    random_phase(RandPerPhase);
    drain();
    write_reg(RegLuma, 32'd2);
    write_reg(RegChroma, 32'd5);
    random_phase(RandPerPhase);
    drain();
    write_reg(RegLuma, $urandom_range(1, 16));
    write_reg(RegChroma, $urandom_range(1, 16));
    random_phase(RandPerPhase);
    drain();

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
sv/gys_pkg.sv
sv/gys_div.sv
sv/gys_dp.sv
sv/gys_ctrl.sv
sv/gamma_aware_ycbcr_subsampler.sv
tb/gamma_aware_ycbcr_subsampler_tb.sv
